// ----- design/nta_pkg.sv -----
// Types and constants shared by the translation table with aging.
// No dependencies; every other file uses it by scoped names.
package nta_pkg;

    localparam logic [15:0] AGE_MAX       = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd30;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [15:0] key_id;
        logic [31:0] inside_address;
        logic [31:0] outside_address;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [31:0] found_inside;
        logic [31:0] found_outside;
        logic        status;
    } t_out;

    typedef struct packed {
        logic        vld;
        t_action     action;
        logic [15:0] key;
        logic [31:0] inside_addr;
        logic [31:0] outside_addr;
        logic        hit;
        logic [31:0] fin;
        logic [31:0] fout;
        logic        free_seen;
    } t_token;

endpackage

// ----- design/nat_table_with_aging.sv -----
// Translation table with idle aging: command front end, timeout register
// and result register around a row of table slots. Depends on nta_pkg, nta_chain.
//
// channel   ports                         handshake
// command   start, busy, i_item           beat taken when start && !busy
// result    o_valid, o_result             one-cycle strobe, no back-pressure
// config    i_cfg_we, i_cfg_data          written when i_cfg_we
//
// Every command holds busy while its token is in the row: the token walks the
// slot row one slot per cycle, and the result strobes in the first cycle that
// busy is low, so a new command may be issued in that same cycle.
// Reset clears all valid bits at once and loads a timeout of 30.
// The result port cannot be stalled.
module nat_table_with_aging #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  nta_pkg::t_in  i_item,
    output logic          o_valid,
    output nta_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data
);

    logic            r_busy;
    logic [15:0]     r_timeout;
    nta_pkg::t_token r_tok_in;
    logic            r_out_vld;
    nta_pkg::t_out   r_out;

    logic            n_busy;
    nta_pkg::t_token n_tok_in;
    nta_pkg::t_out   n_out;

    logic            w_accept;
    logic            w_commit;
    logic            w_insert;
    nta_pkg::t_token w_last;

    assign w_accept = start && !r_busy;
    assign w_insert = (w_last.action == nta_pkg::ACT_INSERT);
    assign w_commit = w_last.vld && w_insert && !w_last.hit && w_last.free_seen;

    always_comb begin
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (w_last.vld) begin
            n_busy = 1'b0;
        end
        n_tok_in.vld          = w_accept;
        n_tok_in.action       = i_item.action;
        n_tok_in.key          = i_item.key_id;
        n_tok_in.inside_addr  = i_item.inside_address;
        n_tok_in.outside_addr = i_item.outside_address;
        n_tok_in.hit          = 1'b0;
        n_tok_in.fin          = '0;
        n_tok_in.fout         = '0;
        n_tok_in.free_seen    = 1'b0;
        n_out.hit           = w_last.hit;
        n_out.found_inside  = w_last.fin;
        n_out.found_outside = w_last.fout;
        n_out.status        = w_insert && !w_last.hit && !w_last.free_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_timeout    <= nta_pkg::TIMEOUT_RESET;
            r_tok_in.vld <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_tok_in  <= n_tok_in;
            r_out_vld <= w_last.vld;
            r_out     <= n_out;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    nta_chain #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_timeout (r_timeout),
        .i_commit  (w_commit),
        .i_tok     (r_tok_in),
        .o_tok     (w_last)
    );

    assign busy     = r_busy;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("busy not raised after command beat");

    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.vld |-> r_busy)
        else $error("token left the row while idle");

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |=> !r_out_vld)
        else $error("result strobe longer than one cycle");

    a_status_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status) |-> !r_out.hit)
        else $error("drop flagged on a hit");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> !r_tok_in.vld)
        else $error("commit while a token is in flight");
`endif

endmodule

// ----- design/nta_cell.sv -----
// One table slot: holds an entry and acts on the token passing through it.
// Depends on nta_pkg.
module nta_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [15:0]     i_timeout,
    input  logic            i_commit,
    input  nta_pkg::t_token i_tok,
    output nta_pkg::t_token o_tok
);

    logic            r_valid;
    logic            r_cand;
    logic [15:0]     r_key;
    logic [31:0]     r_inside;
    logic [31:0]     r_outside;
    logic [15:0]     r_age;
    nta_pkg::t_token r_tok;

    logic            n_valid;
    logic            n_cand;
    logic [15:0]     n_key;
    logic [31:0]     n_inside;
    logic [31:0]     n_outside;
    logic [15:0]     n_age;
    nta_pkg::t_token n_tok;

    logic            w_match;
    logic            w_take;
    logic [15:0]     w_age_inc;

    assign w_age_inc = (r_age == nta_pkg::AGE_MAX) ? r_age : r_age + 16'd1;

    always_comb begin
        n_valid   = r_valid;
        n_cand    = r_cand;
        n_key     = r_key;
        n_inside  = r_inside;
        n_outside = r_outside;
        n_age     = r_age;
        n_tok     = i_tok;
        w_match   = 1'b0;
        w_take    = 1'b0;
        if (i_tok.vld) begin
            unique case (i_tok.action) inside
                nta_pkg::ACT_LOOKUP, nta_pkg::ACT_INSERT: begin
                    w_match = r_valid && (r_key == i_tok.key) && !i_tok.hit;
                    w_take  = (i_tok.action == nta_pkg::ACT_INSERT) && !r_valid
                              && !i_tok.free_seen;
                    if (w_match) begin
                        n_tok.hit  = 1'b1;
                        n_tok.fin  = r_inside;
                        n_tok.fout = r_outside;
                        if (i_tok.action == nta_pkg::ACT_INSERT) begin
                            n_age = '0;
                        end
                    end
                    // stage the new entry; it becomes valid on commit
                    if (w_take) begin
                        n_tok.free_seen = 1'b1;
                        n_key     = i_tok.key;
                        n_inside  = i_tok.inside_addr;
                        n_outside = i_tok.outside_addr;
                        n_age     = '0;
                    end
                end
                nta_pkg::ACT_TICK: begin
                    if (r_valid) begin
                        n_age = w_age_inc;
                        if (w_age_inc > i_timeout) begin
                            n_valid = 1'b0;
                        end
                    end
                end
                nta_pkg::ACT_CLEAR: begin
                    n_valid = 1'b0;
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
            n_cand = w_take;
        end else if (i_commit && r_cand) begin
            n_valid = 1'b1;
            n_cand  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_cand    <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_cand    <= n_cand;
            r_key     <= n_key;
            r_inside  <= n_inside;
            r_outside <= n_outside;
            r_age     <= n_age;
            r_tok     <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- design/nta_chain.sv -----
// Row of table slots; the token enters slot 0 and leaves the last slot.
// Depends on nta_pkg and nta_cell.
module nta_chain #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [15:0]     i_timeout,
    input  logic            i_commit,
    input  nta_pkg::t_token i_tok,
    output nta_pkg::t_token o_tok
);

    nta_pkg::t_token w_tok [0:TABLE_ENTRIES];

    assign w_tok[0] = i_tok;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        nta_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_timeout (i_timeout),
            .i_commit  (i_commit),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1])
        );
    end

    assign o_tok = w_tok[TABLE_ENTRIES];

endmodule

// ----- tb/sv/nat_table_with_aging_tb.sv -----
// Testbench for nat_table_with_aging: directed and random command beats checked
// against an in-bench model of the table. Depends on nta_pkg and the design top.
`timescale 1ns / 100ps

module nat_table_with_aging_tb;

    localparam int ENTRIES  = 64;
    localparam int POOL_LEN = 80;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    nta_pkg::t_in  i_item;
    logic          o_valid;
    nta_pkg::t_out o_result;
    logic          i_cfg_we;
    logic [15:0]   i_cfg_data;

    nat_table_with_aging #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_valid(o_valid),
        .o_result(o_result),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    // model of the table
    logic        tbl_valid [ENTRIES];
    logic [15:0] tbl_key   [ENTRIES];
    logic [31:0] tbl_inside[ENTRIES];
    logic [31:0] tbl_outside[ENTRIES];
    logic [15:0] tbl_age   [ENTRIES];
    logic [15:0] tbl_timeout;

    nta_pkg::t_out pending_replies[$];
    logic [15:0]   key_pool[POOL_LEN];
    int            sender_idle_pct;
    int            mismatch_count;
    int            beats_sent;
    int            hits_seen;
    int            drops_seen;
    int            expiries_seen;

    always #5 i_clk = ~i_clk;

    function automatic nta_pkg::t_out table_apply(input nta_pkg::t_in item);
        nta_pkg::t_out r;
        int            slot;
        int            i;
        r = '0;
        slot = -1;
        case (item.action) inside
            nta_pkg::ACT_LOOKUP, nta_pkg::ACT_INSERT: begin
                for (i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && tbl_valid[i] && tbl_key[i] == item.key_id) slot = i;
                end
                if (slot >= 0) begin
                    r.hit = 1'b1;
                    r.found_inside = tbl_inside[slot];
                    r.found_outside = tbl_outside[slot];
                    hits_seen++;
                    if (item.action == nta_pkg::ACT_INSERT) tbl_age[slot] = '0;
                end else if (item.action == nta_pkg::ACT_INSERT) begin
                    for (i = 0; i < ENTRIES; i++) begin
                        if (slot < 0 && !tbl_valid[i]) slot = i;
                    end
                    if (slot >= 0) begin
                        tbl_valid[slot] = 1'b1;
                        tbl_key[slot] = item.key_id;
                        tbl_inside[slot] = item.inside_address;
                        tbl_outside[slot] = item.outside_address;
                        tbl_age[slot] = '0;
                    end else begin
                        r.status = 1'b1;
                        drops_seen++;
                    end
                end
            end
            nta_pkg::ACT_TICK: begin
                for (i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_age[i] != nta_pkg::AGE_MAX) tbl_age[i] = tbl_age[i] + 16'd1;
                        if (tbl_age[i] > tbl_timeout) begin
                            tbl_valid[i] = 1'b0;
                            expiries_seen++;
                        end
                    end
                end
            end
            default: begin
                for (i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic nta_pkg::t_in make_item(input nta_pkg::t_action act,
                                               input logic [15:0] key);
        nta_pkg::t_in it;
        it.action = act;
        it.key_id = key;
        it.inside_address = $urandom;
        it.outside_address = $urandom;
        return it;
    endfunction

    task automatic send_beat(input nta_pkg::t_in item);
        int unsigned gap;
        gap = 0;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(1, 90);
        @(posedge i_clk);
        repeat (gap) @(posedge i_clk);
        start <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (busy);
        start <= 1'b0;
        pending_replies.push_back(table_apply(item));
        beats_sent++;
    endtask

    task automatic send_cmd(input nta_pkg::t_action act, input logic [15:0] key);
        send_beat(make_item(act, key));
    endtask

    task automatic drain_replies();
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        drain_replies();
        repeat (2) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tbl_timeout = value;
    endtask

    // lookup, insert, refresh, tick and clear at the reset timeout
    task automatic test_basic_ops();
        nta_pkg::t_in it;
        send_cmd(nta_pkg::ACT_LOOKUP, 16'h0000);
        it = make_item(nta_pkg::ACT_INSERT, 16'h0000);
        it.inside_address = '0;
        it.outside_address = '0;
        send_beat(it);
        it = make_item(nta_pkg::ACT_INSERT, 16'hFFFF);
        it.inside_address = '1;
        it.outside_address = '1;
        send_beat(it);
        send_cmd(nta_pkg::ACT_INSERT, 16'h0000);
        send_cmd(nta_pkg::ACT_LOOKUP, 16'hFFFF);
        send_cmd(nta_pkg::ACT_LOOKUP, 16'h1234);
        send_cmd(nta_pkg::ACT_INSERT, 16'h1234);
        send_cmd(nta_pkg::ACT_TICK, 16'h5A5A);
        send_cmd(nta_pkg::ACT_TICK, 16'hA5A5);
        send_cmd(nta_pkg::ACT_LOOKUP, 16'h0000);
        send_cmd(nta_pkg::ACT_CLEAR, 16'hFFFF);
        send_cmd(nta_pkg::ACT_LOOKUP, 16'hFFFF);
    endtask

    // zero, one and maximum timeout
    task automatic test_timeout_limits();
        write_timeout(16'd0);
        send_cmd(nta_pkg::ACT_INSERT, 16'h0005);
        send_cmd(nta_pkg::ACT_TICK, 16'h0000);
        send_cmd(nta_pkg::ACT_LOOKUP, 16'h0005);
        write_timeout(16'd1);
        send_cmd(nta_pkg::ACT_INSERT, 16'h0006);
        send_cmd(nta_pkg::ACT_TICK, 16'h0000);
        send_cmd(nta_pkg::ACT_LOOKUP, 16'h0006);
        send_cmd(nta_pkg::ACT_TICK, 16'h0000);
        send_cmd(nta_pkg::ACT_LOOKUP, 16'h0006);
        write_timeout(16'hFFFF);
        send_cmd(nta_pkg::ACT_INSERT, 16'h0007);
        repeat (3) send_cmd(nta_pkg::ACT_TICK, 16'hFFFF);
        send_cmd(nta_pkg::ACT_LOOKUP, 16'h0007);
    endtask

    // fill every slot, then overflow, refresh and look up
    task automatic test_full_table();
        logic [15:0] base;
        int          i;
        base = 16'($urandom);
        send_cmd(nta_pkg::ACT_CLEAR, 16'($urandom));
        for (i = 0; i < ENTRIES; i++) send_cmd(nta_pkg::ACT_INSERT, base + 16'(i));
        drain_replies();
        for (i = 0; i < 4; i++) send_cmd(nta_pkg::ACT_INSERT, base + 16'(ENTRIES + i));
        send_cmd(nta_pkg::ACT_INSERT, base + 16'($urandom_range(ENTRIES - 1)));
        send_cmd(nta_pkg::ACT_LOOKUP, base + 16'($urandom_range(ENTRIES - 1)));
        send_cmd(nta_pkg::ACT_LOOKUP, base + 16'(ENTRIES));
        send_cmd(nta_pkg::ACT_TICK, 16'($urandom));
    endtask

    // bursts of churn, lookup-heavy and noise traffic over a small key pool
    task automatic test_random_traffic(input int count);
        int               mode;
        int               burst;
        int               roll;
        nta_pkg::t_action act;
        while (count > 0) begin
            if ($urandom_range(3) == 0) drain_replies();
            roll = $urandom_range(99);
            mode = (roll < 45) ? 0 : (roll < 80) ? 1 : 2;
            burst = $urandom_range(10, 40);
            if (burst > count) burst = count;
            count -= burst;
            repeat (burst) begin
                roll = $urandom_range(99);
                case (mode)
                    0: act = (roll < 45) ? nta_pkg::ACT_INSERT :
                             (roll < 80) ? nta_pkg::ACT_LOOKUP :
                             (roll < 98) ? nta_pkg::ACT_TICK : nta_pkg::ACT_CLEAR;
                    1: act = (roll < 60) ? nta_pkg::ACT_LOOKUP :
                             (roll < 90) ? nta_pkg::ACT_INSERT : nta_pkg::ACT_TICK;
                    default: act = nta_pkg::t_action'($urandom_range(3));
                endcase
                if (mode == 2 && $urandom_range(1) == 0)
                    send_cmd(act, 16'($urandom_range(65535)));
                else
                    send_cmd(act, key_pool[$urandom_range(POOL_LEN - 1)]);
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        nta_pkg::t_out want;
        if (i_rst_n && o_valid) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: result with nothing pending: hit=%0b in=%h out=%h status=%0b",
                         $time, o_result.hit, o_result.found_inside,
                         o_result.found_outside, o_result.status);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_result !== want) begin
                    $display("%0t: expected hit=%0b in=%h out=%h status=%0b", $time,
                             want.hit, want.found_inside, want.found_outside, want.status);
                    $display("%0t:   actual hit=%0b in=%h out=%h status=%0b", $time,
                             o_result.hit, o_result.found_inside, o_result.found_outside,
                             o_result.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int i;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        mismatch_count = 0;
        beats_sent = 0;
        hits_seen = 0;
        drops_seen = 0;
        expiries_seen = 0;
        sender_idle_pct = 18;
        tbl_timeout = nta_pkg::TIMEOUT_RESET;
        for (i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_inside[i] = '0;
            tbl_outside[i] = '0;
            tbl_age[i] = '0;
        end
        for (i = 0; i < POOL_LEN; i++) key_pool[i] = 16'($urandom);
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_timeout_limits();

        sender_idle_pct = 18;
        write_timeout(16'd3);
        test_full_table();
        test_random_traffic(130);

        sender_idle_pct = 83;
        write_timeout(16'hFFFF);
        test_random_traffic(90);
        write_timeout(16'd1);
        test_random_traffic(90);

        sender_idle_pct = 0;
        write_timeout(16'($urandom_range(2, 8)));
        test_full_table();
        test_random_traffic(150);

        drain_replies();
        repeat (ENTRIES + 8) @(posedge i_clk);
        $display("covered %0d commands: %0d hits, %0d full-table drops, %0d expiries",
                 beats_sent, hits_seen, drops_seen, expiries_seen);
        $display("timeouts 0, 1, 3, 30 and 65535 with sender idle at 18, 83 and 0 percent");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
